// ===== rtl/p256_field_alu_core_assert.svh =====
// Assertion macros used by the field ALU top level.
`ifndef P256_FIELD_ALU_CORE_ASSERT_SVH
`define P256_FIELD_ALU_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define P256_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication
`define P256_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define P256_ASSERT_IMP(lbl, clk, rst, pre, post)
`define P256_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== rtl/p256fa_pkg.sv =====
// Types, constants and helper functions for the P-256 field ALU.
package p256fa_pkg;
   localparam int NUM_CELLS = 8;
   localparam int WORD_W    = 32;
   localparam int OPND_W    = 256;
   localparam int SUM_W     = 264;
   localparam int TERM_ZERO = 16;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_SUB  = 2'd1,
      OP_MUL  = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   // Prime p = 2^256 - 2^224 + 2^192 + 2^96 - 1, zero extended
   localparam logic [SUM_W-1:0] PRIME =
      {8'h00, 256'hFFFFFFFF00000001000000000000000000000000FFFFFFFFFFFFFFFFFFFFFFFF};

   // Data handed from one multiplier cell to the next
   typedef struct packed {
      opcode_type         op;
      logic [OPND_W-1:0]  a_sh;    // operand a, consumed one word per cell
      logic [OPND_W-1:0]  b;
      logic [OPND_W-1:0]  lo;      // product words shifted out at the bottom
      logic [OPND_W-1:0]  hi;      // running upper part of the product
      logic [SUM_W-1:0]   direct;  // a+b or a-b, signed
   } cell_data_type;

   typedef struct packed {
      opcode_type        op;
      logic [SUM_W-1:0]  value;
   } red_data_type;

   // Product word per fast-reduction term word (TERM_ZERO selects zero)
   localparam logic [4:0] TERM_SEL [9][8] = '{
      '{5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7},
      '{5'd16, 5'd16, 5'd16, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15},
      '{5'd16, 5'd16, 5'd16, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16},
      '{5'd8,  5'd9,  5'd10, 5'd16, 5'd16, 5'd16, 5'd14, 5'd15},
      '{5'd9,  5'd10, 5'd11, 5'd13, 5'd14, 5'd15, 5'd13, 5'd8},
      '{5'd11, 5'd12, 5'd13, 5'd16, 5'd16, 5'd16, 5'd8,  5'd10},
      '{5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd16, 5'd9,  5'd11},
      '{5'd13, 5'd14, 5'd15, 5'd8,  5'd9,  5'd10, 5'd16, 5'd12},
      '{5'd14, 5'd15, 5'd16, 5'd9,  5'd10, 5'd11, 5'd16, 5'd13}
   };

   // Gather one reduction term from the 512-bit product
   function automatic logic [SUM_W-1:0] get_term(input int t,
                                                 input logic [2*OPND_W-1:0] c);
      logic [OPND_W-1:0] r;
      logic [4:0]        idx;
      r = '0;
      for (int j = 0; j < 8; j++) begin
         idx = TERM_SEL[t][j];
         if (idx != 5'(TERM_ZERO)) begin
            r[j*WORD_W +: WORD_W] = c[idx[3:0]*WORD_W +: WORD_W];
         end
      end
      return {8'h00, r};
   endfunction
endpackage

// ===== rtl/p256fa_mul_cell.sv =====
// One multiplier cell: adds one 32-bit row of the a*b product.
module p256fa_mul_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  p256fa_pkg::cell_data_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output p256fa_pkg::cell_data_type out_data
);
   import p256fa_pkg::*;

   logic          valid_ff, valid_in;
   cell_data_type data_ff, data_in;
   logic [2*WORD_W-1:0] part [NUM_CELLS];
   logic [OPND_W-1:0]   even_sum, odd_sum;
   logic [OPND_W+WORD_W-1:0] row_sum;

   // Row products: a word times every b word
   always_comb begin
      for (int j = 0; j < NUM_CELLS; j++) begin
         part[j] = in_data.a_sh[WORD_W-1:0] * in_data.b[j*WORD_W +: WORD_W];
      end
      for (int k = 0; k < NUM_CELLS/2; k++) begin
         even_sum[k*2*WORD_W +: 2*WORD_W] = part[2*k];
         odd_sum[k*2*WORD_W +: 2*WORD_W]  = part[2*k+1];
      end
      row_sum = {32'h0, in_data.hi} + {32'h0, even_sum} + {odd_sum, 32'h0};
   end

   // Shift the finished low word out, keep the rest as running upper part
   always_comb begin
      data_in      = in_data;
      data_in.a_sh = {32'h0, in_data.a_sh[OPND_W-1:WORD_W]};
      data_in.lo   = {row_sum[WORD_W-1:0], in_data.lo[OPND_W-1:WORD_W]};
      data_in.hi   = row_sum[OPND_W+WORD_W-1:WORD_W];
      in_ready     = !valid_ff || out_ready;
      valid_in     = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== rtl/p256fa_reduce.sv =====
// Fast reduction, fold of the top bits and final canonical correction.
module p256fa_reduce (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  p256fa_pkg::cell_data_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [255:0]            out_result
);
   import p256fa_pkg::*;

   // Stage 0: term sums, 1: difference, 2: fold, 3: canonical result
   logic [3:0]   valid_ff, valid_in, ready;
   red_data_type pos_ff, neg_ff, diff_ff, fold_ff;
   red_data_type pos_in, neg_in, diff_in, fold_in;
   logic [OPND_W-1:0] res_ff, res_in;
   logic [2*OPND_W-1:0] prod;
   logic [SUM_W-1:0] hs, cand;

   // Stage ready chain
   always_comb begin
      ready[3] = !valid_ff[3] || out_ready;
      for (int s = 2; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int s = 1; s < 4; s++) begin
         valid_in[s] = ready[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   // Signed word sums s1+2s2+2s3+s4+s5 and s6+s7+s8+s9
   always_comb begin
      prod      = {in_data.hi, in_data.lo};
      pos_in.op = in_data.op;
      neg_in.op = in_data.op;
      if (in_data.op == OP_MUL) begin
         pos_in.value = get_term(0, prod) + (get_term(1, prod) << 1)
                      + (get_term(2, prod) << 1) + get_term(3, prod) + get_term(4, prod);
         neg_in.value = get_term(5, prod) + get_term(6, prod)
                      + get_term(7, prod) + get_term(8, prod);
      end else begin
         pos_in.value = in_data.direct;
         neg_in.value = '0;
      end
      diff_in.op    = pos_ff.op;
      diff_in.value = pos_ff.value - neg_ff.value;
   end

   // Fold bits above 2^256: 2^256 = 2^224 - 2^192 - 2^96 + 1 mod p
   always_comb begin
      hs = {{(SUM_W-5){diff_ff.value[OPND_W+4]}}, diff_ff.value[OPND_W+4:OPND_W]};
      fold_in.op    = diff_ff.op;
      fold_in.value = {8'h00, diff_ff.value[OPND_W-1:0]} + (hs << 224)
                    - (hs << 192) - (hs << 96) + hs;
   end

   // Value lies in (-p, 2p): one add or subtract of p
   always_comb begin
      if (fold_ff.value[SUM_W-1]) begin
         cand = fold_ff.value + PRIME;
      end else if (fold_ff.value >= PRIME) begin
         cand = fold_ff.value - PRIME;
      end else begin
         cand = fold_ff.value;
      end
      res_in = (fold_ff.op == OP_NONE) ? '0 : cand[OPND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && ready[0]) begin
         pos_ff <= pos_in;
         neg_ff <= neg_in;
      end
      if (valid_ff[0] && ready[1]) begin
         diff_ff <= diff_in;
      end
      if (valid_ff[1] && ready[2]) begin
         fold_ff <= fold_in;
      end
      if (valid_ff[2] && ready[3]) begin
         res_ff <= res_in;
      end
   end

   assign in_ready   = ready[0];
   assign out_valid  = valid_ff[3];
   assign out_result = res_ff;
endmodule

// ===== rtl/p256_field_alu_core.sv =====
// Top level of the P-256 field ALU: multiplier cell chain and reduction.
//
//   channel | ports  | moves
//   --------+--------+---------------------------------------------
//   input   | req_*  | opcode and operands a, b (four 64-bit words)
//   output  | rsp_*  | result r, canonical mod p (four 64-bit words)
//
// Eight multiplier cells (one 32x256 row each) and four reduction stages;
// one request per cycle is accepted unless an output stall backs up.
// Add and subtract pass the cells unchanged and share the same latency.
// Every stage has its own valid bit, so bubbles close up under a stall.
// Reset clears the valid bits only.
module p256_field_alu_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_a_word0,
   input  logic [63:0] req_a_word1,
   input  logic [63:0] req_a_word2,
   input  logic [63:0] req_a_word3,
   input  logic [63:0] req_b_word0,
   input  logic [63:0] req_b_word1,
   input  logic [63:0] req_b_word2,
   input  logic [63:0] req_b_word3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_r_word0,
   output logic [63:0] rsp_r_word1,
   output logic [63:0] rsp_r_word2,
   output logic [63:0] rsp_r_word3
);
   import p256fa_pkg::*;
`include "p256_field_alu_core_assert.svh"

   cell_data_type entry;
   cell_data_type link_data [NUM_CELLS+1];
   logic [NUM_CELLS:0] link_valid, link_ready;
   logic [OPND_W-1:0]  a_full, b_full, result;

   // Request into the first cell; add and subtract computed up front
   always_comb begin
      a_full       = {req_a_word3, req_a_word2, req_a_word1, req_a_word0};
      b_full       = {req_b_word3, req_b_word2, req_b_word1, req_b_word0};
      entry.op     = opcode_type'(req_opcode);
      entry.a_sh   = a_full;
      entry.b      = b_full;
      entry.lo     = '0;
      entry.hi     = '0;
      entry.direct = (req_opcode == OP_SUB) ? ({8'h00, a_full} - {8'h00, b_full})
                                            : ({8'h00, a_full} + {8'h00, b_full});
   end

   assign link_data[0]  = entry;
   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];

   // Multiplier cell chain
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      p256fa_mul_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   p256fa_reduce u_reduce (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (link_valid[NUM_CELLS]),
      .in_ready   (link_ready[NUM_CELLS]),
      .in_data    (link_data[NUM_CELLS]),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_r_word0 = result[63:0];
   assign rsp_r_word1 = result[127:64];
   assign rsp_r_word2 = result[191:128];
   assign rsp_r_word3 = result[255:192];

   // Every result is canonical
   `P256_ASSERT_IMP(a_canonical, clock, reset, rsp_valid, {8'h00, result} < PRIME)
   // An accepted request lands in the first cell
   `P256_ASSERT_NXT(a_enter, clock, reset, req_valid && req_ready, link_valid[1])
   // Refusing a request means the first cell holds a stalled item
   `P256_ASSERT_IMP(a_full_stall, clock, reset, !req_ready,
                    link_valid[1] && !link_ready[1])
endmodule

// ===== bench/tb_p256_field_alu_core.sv =====
// Self-checking testbench for the P-256 field ALU core: random and corner requests.
module tb_p256_field_alu_core;
   import p256fa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LAT   = 12;
   localparam int STALL_LIM  = 5000;
   localparam int NUM_RANDOM = 1200;
   localparam int LONG_HOLD  = 60;

   // Prime and useful patterns
   localparam logic [255:0] P_MOD =
      256'hFFFFFFFF00000001000000000000000000000000FFFFFFFFFFFFFFFFFFFFFFFF;
   localparam logic [255:0] ALL_ONES = {256{1'b1}};

   typedef struct {
      opcode_type   op;
      logic [255:0] a;
      logic [255:0] b;
      int           gap;
      bit           drain;  // wait for every result before offering this one
   } alu_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [63:0] req_a_word0, req_a_word1, req_a_word2, req_a_word3;
   logic [63:0] req_b_word0, req_b_word1, req_b_word2, req_b_word3;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_r_word0, rsp_r_word1, rsp_r_word2, rsp_r_word3;

   alu_req_type  pending_reqs[$];
   logic [255:0] expected_sums[$];
   int           error_count = 0;
   int           sent_count = 0;
   int           got_count = 0;
   int           idle_cycles = 0;
   int           op_counts[4] = '{0, 0, 0, 0};
   bit           stim_done = 0;
   bit           hold_req = 0;

   p256_field_alu_core dut (.*);

   always #5 clock = ~clock;

   // Reduce a nonnegative value below 2^512 modulo p
   function automatic logic [255:0] mod_p(input logic [511:0] x);
      logic [511:0] pp;
      pp = {256'd0, P_MOD};
      return 256'(x % pp);
   endfunction

   // Expected field result for one request
   function automatic logic [255:0] field_result(input opcode_type op,
                                                 input logic [255:0] a,
                                                 input logic [255:0] b);
      logic [255:0] ar, br;
      ar = mod_p({256'd0, a});
      br = mod_p({256'd0, b});
      case (op)
         OP_ADD: begin
            return mod_p({256'd0, ar} + {256'd0, br});
         end
         OP_SUB: begin
            return mod_p({256'd0, ar} + {256'd0, P_MOD} - {256'd0, br});
         end
         OP_MUL: begin
            return mod_p({256'd0, ar} * {256'd0, br});
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   function automatic logic [255:0] rand_opnd();
      logic [255:0] v;
      int           kind;
      for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
      kind = $urandom_range(0, 9);
      case (kind)
         0: v = P_MOD - 256'($urandom_range(0, 3));
         1: v = P_MOD + 256'($urandom_range(0, 3));
         2: v = ALL_ONES - 256'($urandom_range(0, 3));
         3: v = 256'($urandom_range(0, 3));
         default: ;
      endcase
      return v;
   endfunction

   task automatic push_req(input opcode_type op, input logic [255:0] a,
                           input logic [255:0] b, input bit drain);
      alu_req_type r;
      r.op = op;
      r.a = a;
      r.b = b;
      r.drain = drain;
      r.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      pending_reqs.push_back(r);
   endtask

   // Stimulus: corners first, then random bursts
   initial begin
      opcode_type ops[4];
      ops = '{OP_ADD, OP_SUB, OP_MUL, OP_NONE};
      foreach (ops[i]) begin
         push_req(ops[i], '0, '0, 0);
         push_req(ops[i], ALL_ONES, ALL_ONES, 0);
         push_req(ops[i], P_MOD, 256'd1, 0);
         push_req(ops[i], P_MOD - 1, P_MOD - 1, 0);
         push_req(ops[i], 256'd1, P_MOD + 1, 0);
      end
      // Squaring and reduction wraparound
      push_req(OP_MUL, P_MOD - 1, P_MOD - 1, 0);
      push_req(OP_SUB, '0, 256'd1, 0);
      push_req(OP_ADD, P_MOD - 1, 256'd1, 0);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         logic [255:0] a;
         opcode_type   op;
         a = rand_opnd();
         op = opcode_type'(($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2));
         push_req(op, a, ($urandom_range(0, 7) == 0) ? a : rand_opnd(),
                  (i % 400) == 399);
      end
      // Long burst with no gaps for the backpressure window
      for (int i = 0; i < 40; i++) begin
         push_req(OP_MUL, rand_opnd(), rand_opnd(), 0);
         pending_reqs[$].gap = 0;
      end
      stim_done = 1;
   end

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_reqs[0].drain && expected_sums.size() != 0) begin
               req_valid <= 1'b0;
            end else if (idle_cycles < pending_reqs[0].gap) begin
               req_valid <= 1'b0;
               idle_cycles <= idle_cycles + 1;
            end else begin
               alu_req_type r;
               r = pending_reqs.pop_front();
               idle_cycles <= 0;
               req_valid <= 1'b1;
               req_opcode <= r.op;
               {req_a_word3, req_a_word2, req_a_word1, req_a_word0} <= r.a;
               {req_b_word3, req_b_word2, req_b_word1, req_b_word0} <= r.b;
               expected_sums.push_back(field_result(r.op, r.a, r.b));
               op_counts[r.op]++;
            end
         end
      end
   end

   // Result monitor with random hold-off
   int rsp_wait = 0;
   int long_count = 0;
   always @(posedge clock) begin
      logic [255:0] got, want;
      int           draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_r_word3, rsp_r_word2, rsp_r_word1, rsp_r_word0};
            got_count++;
            if (expected_sums.size() == 0) begin
               $display("%0t: result with no request pending, actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_sums.pop_front();
               for (int k = 0; k < 4; k++) begin
                  if (got[k*64 +: 64] !== want[k*64 +: 64]) begin
                     $display("%0t: r_word%0d expected %h actual %h", $time, k,
                              want[k*64 +: 64], got[k*64 +: 64]);
                     error_count++;
                  end
               end
            end
         end
         // One long stall once the final burst is underway
         if (stim_done && pending_reqs.size() < 30 && long_count < LONG_HOLD) begin
            long_count <= long_count + 1;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_ready && rsp_valid) begin
            // A zero draw keeps ready up for a back-to-back result
            draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            rsp_wait <= (draw > 0) ? draw - 1 : 0;
            rsp_ready <= (draw == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Reset, completion wait and watchdog
   initial begin
      int quiet;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = '0;
      {req_a_word3, req_a_word2, req_a_word1, req_a_word0} = '0;
      {req_b_word3, req_b_word2, req_b_word1, req_b_word0} = '0;
      rsp_ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      quiet = 0;
      while (!(stim_done && pending_reqs.size() == 0 && !req_valid
               && expected_sums.size() == 0) && quiet < STALL_LIM) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      if (quiet >= STALL_LIM) begin
         $display("Mismatches found");
         $finish;
      end else begin
         repeat (PIPE_LAT * 2) @(posedge clock);
         $display("Covered %0d requests (add %0d, sub %0d, mul %0d, unused %0d),",
                  sent_count, op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
         $display("with corner operands, random stalls and a long output stall.");
         if (error_count == 0 && !rsp_valid) begin
            $display("No mismatches found");
         end else begin
            $display("Mismatches found");
         end
         $finish;
      end
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/p256fa_pkg.sv
rtl/p256fa_mul_cell.sv
rtl/p256fa_reduce.sv
rtl/p256_field_alu_core.sv
bench/tb_p256_field_alu_core.sv
